// ===== rtl/csl_pkg.sv =====
`timescale 1ns / 1ps
// shared types, token codes and keyword table for the c subset lexer
// no dependencies

package csl_pkg;

	localparam int OFFSET_BITS_DEF     = 16;
	localparam int KEYWORD_MAX_LEN_DEF = 11;
	localparam int QDEPTH              = 4;
	localparam int NKW                 = 16;

	localparam logic [1:0] ST_TOKEN  = 2'd0;
	localparam logic [1:0] ST_BADCHR = 2'd1;
	localparam logic [1:0] ST_OPENSTR = 2'd2;

	localparam logic [5:0] K_NONE   = 6'd0;
	localparam logic [5:0] K_LPAREN = 6'd0;
	localparam logic [5:0] K_RPAREN = 6'd1;
	localparam logic [5:0] K_LBRACE = 6'd2;
	localparam logic [5:0] K_RBRACE = 6'd3;
	localparam logic [5:0] K_LBRACK = 6'd4;
	localparam logic [5:0] K_RBRACK = 6'd5;
	localparam logic [5:0] K_COMMA  = 6'd6;
	localparam logic [5:0] K_DOT    = 6'd7;
	localparam logic [5:0] K_MINUS  = 6'd8;
	localparam logic [5:0] K_PLUS   = 6'd9;
	localparam logic [5:0] K_SEMI   = 6'd10;
	localparam logic [5:0] K_SLASH  = 6'd11;
	localparam logic [5:0] K_STAR   = 6'd12;
	localparam logic [5:0] K_BANG   = 6'd13;
	localparam logic [5:0] K_ASSIGN = 6'd15;
	localparam logic [5:0] K_GT     = 6'd17;
	localparam logic [5:0] K_LT     = 6'd19;
	localparam logic [5:0] K_IDENT  = 6'd25;
	localparam logic [5:0] K_STRING = 6'd26;
	localparam logic [5:0] K_NUMBER = 6'd27;
	localparam logic [5:0] KW_KIND_BASE = 6'd28;
	localparam logic [5:0] K_END    = 6'd44;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [15:0] col;
		logic        eor;
	} res_t;

	typedef struct packed {
		logic [2:0]      cnt;
		res_t [3:0]      res;
	} bundle_t;

	// keyword text, first char in the highest used byte
	localparam logic [127:0] KW_TEXT [NKW] = '{
		128'("struct"), 128'("enum"), 128'("true"), 128'("false"),
		128'("static"), 128'("const"), 128'("unsigned"), 128'("short"),
		128'("long"), 128'("bool"), 128'("char"), 128'("int"),
		128'("float"), 128'("NULL"), 128'("float3"), 128'({"ARRAY_", "COUNT"})};
	localparam logic [7:0] KW_LEN [NKW] = '{
		8'd6, 8'd4, 8'd4, 8'd5, 8'd6, 8'd5, 8'd8, 8'd5,
		8'd4, 8'd4, 8'd4, 8'd3, 8'd5, 8'd4, 8'd6, 8'd11};

	function automatic logic [7:0] kw_char(input int k, input int j);
		int sh;
		sh = 8 * (int'(KW_LEN[k]) - 1 - j);
		if (sh < 0)
			return 8'd0;
		return 8'(KW_TEXT[k] >> sh);
	endfunction

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (v > 32'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

// ===== rtl/csl_front.sv =====
`timescale 1ns / 1ps
// front end: accepts text bytes, runs the scanner and builds a bundle of
// up to four results per byte; depends on csl_pkg

module csl_front #(
	parameter int OFFSET_BITS     = csl_pkg::OFFSET_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = csl_pkg::KEYWORD_MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        char_byte,
	input  logic              last_byte,
	output logic              push,
	output csl_pkg::bundle_t  push_data
);

	localparam int WIDX = (KEYWORD_MAX_LEN > 1) ? $clog2(KEYWORD_MAX_LEN) : 1;
	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	localparam logic [3:0] M_IDLE = 4'd0, M_OP = 4'd1, M_SLASH = 4'd2, M_LINECMT = 4'd3,
		M_BLOCK = 4'd4, M_BLOCKSTAR = 4'd5, M_STRING = 4'd6, M_INT = 4'd7,
		M_DOT = 4'd8, M_FRAC = 4'd9, M_WORD = 4'd10;

	logic [3:0]             mode_q, mode_d;
	logic [OFFSET_BITS-1:0] ts_q, ts_d, bpos_q, bpos_d;
	logic [15:0]            line_q, line_d, col_q, col_d;
	logic [7:0]             pend_q, pend_d;
	logic [7:0]             wb_q [KEYWORD_MAX_LEN];
	logic                   wb_we;
	logic [WIDX-1:0]        wb_idx;
	logic [5:0]             word_kind;
	logic [5:0]             word_kind_last;
	logic [2:0]             n;
	csl_pkg::res_t          res [4];

	function automatic csl_pkg::res_t mk(input logic [1:0] st, input logic [5:0] kind,
		input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS-1:0] e,
		input logic [15:0] ln, input logic [15:0] cl);
		csl_pkg::res_t r;
		r.status = st;
		r.kind   = kind;
		r.start  = csl_pkg::sat16(32'(s));
		r.len    = csl_pkg::sat16(32'((e > s) ? e - s : '0));
		r.line   = ln;
		r.col    = cl;
		r.eor    = 1'b0;
		return r;
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] p);
		if (p == "=") return csl_pkg::K_ASSIGN;
		if (p == ">") return csl_pkg::K_GT;
		if (p == "<") return csl_pkg::K_LT;
		return csl_pkg::K_BANG;
	endfunction

	function automatic logic is_digit(input logic [7:0] x);
		return x >= "0" && x <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] x);
		return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
	endfunction

	// parallel keyword compare against the buffered word
	always_comb begin
		logic hit;
		word_kind = csl_pkg::K_IDENT;
		for (int k = 0; k < csl_pkg::NKW; k++) begin
			hit = (pend_q == csl_pkg::KW_LEN[k]);
			for (int j = 0; j < KEYWORD_MAX_LEN; j++)
				if (j < int'(csl_pkg::KW_LEN[k]) && wb_q[j] != csl_pkg::kw_char(k, j))
					hit = 1'b0;
			if (hit)
				word_kind = 6'(csl_pkg::KW_KIND_BASE + k);
		end
	end

	always_comb begin
		logic [7:0]             c;
		logic [OFFSET_BITS-1:0] pos, nxt, dot;
		logic                   redo;
		c   = char_byte;
		pos = bpos_q;
		nxt = (pos != POS_MAX) ? pos + 1'b1 : pos;
		mode_d = mode_q;
		ts_d   = ts_q;
		line_d = line_q;
		col_d  = (col_q != 16'hFFFF) ? col_q + 16'd1 : col_q;
		pend_d = pend_q;
		redo   = 1'b0;
		wb_we  = 1'b0;
		wb_idx = '0;
		n      = 3'd0;
		dot    = '0;
		for (int i = 0; i < 4; i++)
			res[i] = '0;

		unique case (mode_q)
			M_OP: begin
				mode_d = M_IDLE;
				if (c == "=") begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, op_kind(pend_q) + 6'd1, ts_d, nxt, line_d, 16'd0);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, op_kind(pend_q), ts_d, pos, line_d, 16'd0);
					n = n + 3'd1;
					redo = 1'b1;
				end
			end
			M_SLASH: begin
				if (c == "/")
					mode_d = M_LINECMT;
				else if (c == "*")
					mode_d = M_BLOCK;
				else begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_SLASH, ts_d, pos, line_d, 16'd0);
					n = n + 3'd1;
					mode_d = M_IDLE;
					redo = 1'b1;
				end
			end
			M_LINECMT: begin
				if (c == "\n") begin
					mode_d = M_IDLE;
					redo = 1'b1;
				end
			end
			M_BLOCK: begin
				if (c == "*")
					mode_d = M_BLOCKSTAR;
				else if (c == "\n") begin
					if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
					col_d = 16'd1;
				end
			end
			M_BLOCKSTAR: begin
				if (c == "/")
					mode_d = M_IDLE;
				else if (c != "*") begin
					mode_d = M_BLOCK;
					if (c == "\n") begin
						if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
						col_d = 16'd1;
					end
				end
			end
			M_STRING: begin
				if (c == "\"") begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_STRING, ts_d, nxt, line_d, 16'd0);
					n = n + 3'd1;
					mode_d = M_IDLE;
				end else if (c == "\n") begin
					if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
					col_d = 16'd1;
				end
			end
			M_INT: begin
				if (c == ".")
					mode_d = M_DOT;
				else if (!is_digit(c)) begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_NUMBER, ts_d, pos, line_d, 16'd0);
					n = n + 3'd1;
					mode_d = M_IDLE;
					redo = 1'b1;
				end
			end
			M_DOT: begin
				if (is_digit(c))
					mode_d = M_FRAC;
				else begin
					dot = (pos > ts_d) ? pos - 1'b1 : pos;
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_NUMBER, ts_d, dot, line_d, 16'd0);
					n = n + 3'd1;
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_DOT, dot, pos, line_d, 16'd0);
					n = n + 3'd1;
					mode_d = M_IDLE;
					redo = 1'b1;
				end
			end
			M_FRAC: begin
				if (c == "f") begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_NUMBER, ts_d, nxt, line_d, 16'd0);
					n = n + 3'd1;
					mode_d = M_IDLE;
				end else if (!is_digit(c)) begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_NUMBER, ts_d, pos, line_d, 16'd0);
					n = n + 3'd1;
					mode_d = M_IDLE;
					redo = 1'b1;
				end
			end
			M_WORD: begin
				if (is_alpha(c) || is_digit(c)) begin
					if (pend_q < 8'(KEYWORD_MAX_LEN)) begin
						wb_we  = 1'b1;
						wb_idx = WIDX'(pend_q);
					end
					if (pend_q != 8'hFF) pend_d = pend_q + 8'd1;
				end else begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, word_kind, ts_d, pos, line_d, 16'd0);
					n = n + 3'd1;
					mode_d = M_IDLE;
					redo = 1'b1;
				end
			end
			default: begin
				mode_d = M_IDLE;
				redo = 1'b1;
			end
		endcase

		if (redo) begin
			ts_d = pos;
			unique case (c)
				"(", ")", "{", "}", "[", "]", ",", ".", "-", "+", ";", "*": begin
					unique case (c)
						"(": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_LPAREN, pos, nxt, line_d, 16'd0);
						")": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_RPAREN, pos, nxt, line_d, 16'd0);
						"{": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_LBRACE, pos, nxt, line_d, 16'd0);
						"}": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_RBRACE, pos, nxt, line_d, 16'd0);
						"[": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_LBRACK, pos, nxt, line_d, 16'd0);
						"]": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_RBRACK, pos, nxt, line_d, 16'd0);
						",": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_COMMA, pos, nxt, line_d, 16'd0);
						".": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_DOT, pos, nxt, line_d, 16'd0);
						"-": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_MINUS, pos, nxt, line_d, 16'd0);
						"+": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_PLUS, pos, nxt, line_d, 16'd0);
						";": res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_SEMI, pos, nxt, line_d, 16'd0);
						default: res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_STAR, pos, nxt, line_d, 16'd0);
					endcase
					n = n + 3'd1;
				end
				"!", "=", "<", ">": begin
					pend_d = c;
					mode_d = M_OP;
				end
				"/": mode_d = M_SLASH;
				"#": mode_d = M_LINECMT;
				" ", "\r", "\t": ;
				"\n": begin
					if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
					col_d = 16'd0;
				end
				"\"": mode_d = M_STRING;
				default: begin
					if (is_digit(c))
						mode_d = M_INT;
					else if (is_alpha(c)) begin
						wb_we  = 1'b1;
						wb_idx = '0;
						pend_d = 8'd1;
						mode_d = M_WORD;
					end else begin
						res[n[1:0]] = mk(csl_pkg::ST_BADCHR, csl_pkg::K_NONE, pos, nxt, line_d, col_d);
						n = n + 3'd1;
					end
				end
			endcase
		end

		bpos_d = nxt;
		if (last_byte) begin
			unique case (mode_d)
				M_OP: begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, op_kind(pend_d), ts_d, nxt, line_d, 16'd0);
					n = n + 3'd1;
				end
				M_SLASH: begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_SLASH, ts_d, nxt, line_d, 16'd0);
					n = n + 3'd1;
				end
				M_INT, M_FRAC: begin
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_NUMBER, ts_d, nxt, line_d, 16'd0);
					n = n + 3'd1;
				end
				M_DOT: begin
					dot = (nxt > ts_d) ? nxt - 1'b1 : nxt;
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_NUMBER, ts_d, dot, line_d, 16'd0);
					n = n + 3'd1;
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_DOT, dot, nxt, line_d, 16'd0);
					n = n + 3'd1;
				end
				M_WORD: begin
					// a word opened by this byte is a single letter, never a keyword
					res[n[1:0]] = mk(csl_pkg::ST_TOKEN, (mode_q == M_WORD && !redo) ?
						word_kind_last : csl_pkg::K_IDENT, ts_d, nxt, line_d, 16'd0);
					n = n + 3'd1;
				end
				M_STRING: begin
					res[n[1:0]] = mk(csl_pkg::ST_OPENSTR, csl_pkg::K_NONE, ts_d, nxt, line_d, col_d);
					n = n + 3'd1;
				end
				default: ;
			endcase
			res[n[1:0]] = mk(csl_pkg::ST_TOKEN, csl_pkg::K_END, nxt, nxt, line_d, 16'd0);
			n = n + 3'd1;
			mode_d = M_IDLE;
			ts_d   = '0;
			bpos_d = '0;
			line_d = 16'd1;
			col_d  = 16'd0;
			pend_d = 8'd0;
		end
		if (n != 3'd0)
			res[2'(n - 3'd1)].eor = 1'b1;
	end

	// keyword compare for a word that this byte extends and the text ends
	always_comb begin
		logic hit;
		logic [7:0] len;
		len = (pend_q != 8'hFF) ? pend_q + 8'd1 : pend_q;
		word_kind_last = csl_pkg::K_IDENT;
		for (int k = 0; k < csl_pkg::NKW; k++) begin
			hit = (len == csl_pkg::KW_LEN[k]);
			for (int j = 0; j < KEYWORD_MAX_LEN; j++)
				if (j < int'(csl_pkg::KW_LEN[k])) begin
					if (j == int'(pend_q)) begin
						if (char_byte != csl_pkg::kw_char(k, j)) hit = 1'b0;
					end else if (wb_q[j] != csl_pkg::kw_char(k, j))
						hit = 1'b0;
				end
			if (hit)
				word_kind_last = 6'(csl_pkg::KW_KIND_BASE + k);
		end
	end

	assign push = acc && (n != 3'd0);
	always_comb begin
		push_data.cnt = n;
		for (int i = 0; i < 4; i++)
			push_data.res[i] = res[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			ts_q   <= '0;
			bpos_q <= '0;
			line_q <= 16'd1;
			col_q  <= 16'd0;
			pend_q <= 8'd0;
		end else if (acc) begin
			mode_q <= mode_d;
			ts_q   <= ts_d;
			bpos_q <= bpos_d;
			line_q <= line_d;
			col_q  <= col_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && wb_we)
			wb_q[wb_idx] <= char_byte;
	end

endmodule

// ===== rtl/csl_queue.sv =====
`timescale 1ns / 1ps
// back end: bundle queue and result serializer, one result per unstalled cycle
// depends on csl_pkg

module csl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csl_pkg::bundle_t  push_data,
	output logic              full,
	output logic              token_valid,
	input  logic              token_stall,
	output csl_pkg::res_t     head_res
);

	localparam int PW = $clog2(csl_pkg::QDEPTH);

	csl_pkg::bundle_t mem [csl_pkg::QDEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      count_q;
	logic [1:0]       sub_q;
	logic             take, pop;

	assign full        = (count_q == (PW+1)'(csl_pkg::QDEPTH));
	assign token_valid = (count_q != '0);
	assign head_res    = mem[rd_q].res[sub_q];
	assign take        = token_valid && !token_stall;
	assign pop         = take && ({1'b0, sub_q} == mem[rd_q].cnt - 3'd1);

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
			sub_q   <= 2'd0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop) begin
				rd_q  <= rd_q + 1'b1;
				sub_q <= 2'd0;
			end else if (take)
				sub_q <= sub_q + 2'd1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> (mem[rd_q].cnt != 3'd0)) else $error("empty bundle at head");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1)) else $error("count slip");
	a_sub_bound: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> ({1'b0, sub_q} < mem[rd_q].cnt)) else $error("result index past bundle");

endmodule

// ===== rtl/c_subset_lexer.sv =====
`timescale 1ns / 1ps
// Streaming lexer for a small C subset.
// Input channel (char_valid/char_stall): one text byte per request, last_byte marks
// the final byte of a text. Output channel (token_valid/token_stall): one result per
// request with status, token_kind, start_offset, lexeme_length, line_number, column
// and end_of_run on the last result that a byte caused.
// A byte is scanned in the cycle it is accepted; its results (zero to four) enter a
// four-bundle queue, are registered there and leave one per unstalled cycle.
// Throughput: one byte per cycle while the queue has room; the output side sets the
// pace to one result per unstalled cycle, so bursts of tokens fill the queue.
// char_stall rises when the queue is full; a stalled output result holds its fields.
// After reset and after each final byte the scanner starts a new text at offset 0,
// line 1. Offsets count in OFFSET_BITS and saturate; output fields hold at 65535.
// Keyword buffer holds the first KEYWORD_MAX_LEN bytes of the current word.
// depends on csl_pkg, csl_front, csl_queue

module c_subset_lexer #(
	parameter int OFFSET_BITS     = csl_pkg::OFFSET_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = csl_pkg::KEYWORD_MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_byte,
	input  logic        last_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [1:0]  status,
	output logic [5:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [15:0] lexeme_length,
	output logic [15:0] line_number,
	output logic [15:0] column,
	output logic        end_of_run
);

	logic             full, push;
	csl_pkg::bundle_t push_data;
	csl_pkg::res_t    head_res;

	assign char_stall = full;

	csl_front #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .acc(char_valid && !full),
		.char_byte(char_byte), .last_byte(last_byte),
		.push(push), .push_data(push_data));

	csl_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.token_valid(token_valid), .token_stall(token_stall), .head_res(head_res));

	assign status        = head_res.status;
	assign token_kind    = head_res.kind;
	assign start_offset  = head_res.start;
	assign lexeme_length = head_res.len;
	assign line_number   = head_res.line;
	assign column        = head_res.col;
	assign end_of_run    = head_res.eor;

endmodule

// ===== test/tb_c_subset_lexer.sv =====
`timescale 1ns / 1ps
// self-checking testbench for c_subset_lexer: directed and random texts with random idling
// carries its own token predictor; depends on csl_pkg and the lexer rtl

module tb_c_subset_lexer;

	localparam int LIMIT = 100000;
	localparam int HOLD_CYCLES = 400;
	localparam int WB_LEN = csl_pkg::KEYWORD_MAX_LEN_DEF;
	localparam string PUNCT = "(){}[],.-+;";

	typedef enum logic [3:0] {
		S_IDLE, S_OP, S_SLASH, S_LCMT, S_BLK, S_BLKSTAR, S_STR, S_INT, S_DOT, S_FRAC, S_WORD
	} scan_e;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         pause;
		bit         hold;
		int         ph;
	} req_t;

	logic        clk, arst_n;
	logic        char_valid, char_stall, last_byte;
	logic [7:0]  char_byte;
	logic        token_valid, token_stall;
	logic [1:0]  status;
	logic [5:0]  token_kind;
	logic [15:0] start_offset, lexeme_length, line_number, column;
	logic        end_of_run;

	c_subset_lexer dut (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	req_t          pending[$];
	csl_pkg::res_t expected_tokens[$];
	byte           txt[$];
	int            phase, accepted, queued, cycles, fails;
	bit            char_took, hold_req;
	int            hold_left;

	string kw_names[16] = '{"struct", "enum", "true", "false", "static", "const", "unsigned",
		"short", "long", "bool", "char", "int", "float", "NULL", "float3",
		string'({"ARRAY_", "COUNT"})};

	// lexer state mirror
	scan_e         mode;
	logic [15:0]   tstart, bpos, lcount, lcol;
	logic [7:0]    wbuf [WB_LEN];
	logic [7:0]    pend;
	csl_pkg::res_t rbuf [4];
	int            rn;

	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alp(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [5:0] op_kind(logic [7:0] c);
		if (c == "=") return csl_pkg::K_ASSIGN;
		if (c == ">") return csl_pkg::K_GT;
		if (c == "<") return csl_pkg::K_LT;
		return csl_pkg::K_BANG;
	endfunction

	task automatic emit(logic [1:0] st, logic [5:0] k, logic [15:0] s, logic [15:0] e,
			logic [15:0] c);
		csl_pkg::res_t r;
		if (rn < 4) begin
			r.status = st;
			r.kind = k;
			r.start = s;
			r.len = (e > s) ? e - s : 16'd0;
			r.line = lcount;
			r.col = c;
			r.eor = 1'b0;
			rbuf[rn] = r;
			rn++;
		end
	endtask

	task automatic tok(logic [5:0] k, logic [15:0] e);
		emit(csl_pkg::ST_TOKEN, k, tstart, e, 16'd0);
	endtask

	task automatic newline(logic [15:0] c);
		if (lcount != 16'hFFFF) lcount++;
		lcol = c;
	endtask

	task automatic flush_word(logic [15:0] e);
		logic [5:0] k;
		string w;
		k = csl_pkg::K_IDENT;
		if (pend <= WB_LEN) begin
			w = "";
			for (int i = 0; i < pend; i++) w = {w, string'(wbuf[i])};
			for (int i = 0; i < 16; i++)
				if (kw_names[i] == w) k = csl_pkg::KW_KIND_BASE + 6'(i);
		end
		tok(k, e);
	endtask

	task automatic idle_byte(logic [7:0] c, logic [15:0] pos, logic [15:0] nxt);
		int single;
		single = -1;
		for (int i = 0; i < PUNCT.len(); i++)
			if (PUNCT[i] == c) single = i;
		if (c == "*") single = csl_pkg::K_STAR;
		tstart = pos;
		if (single >= 0) tok(6'(single), nxt);
		else if (c == "!" || c == "=" || c == "<" || c == ">") begin
			pend = c;
			mode = S_OP;
		end else if (c == "/") mode = S_SLASH;
		else if (c == "#") mode = S_LCMT;
		else if (c == " " || c == 8'h0D || c == 8'h09) begin
		end else if (c == 8'h0A) newline(16'd0);
		else if (c == "\"") mode = S_STR;
		else if (is_dig(c)) mode = S_INT;
		else if (is_alp(c)) begin
			wbuf[0] = c;
			pend = 8'd1;
			mode = S_WORD;
		end else emit(csl_pkg::ST_BADCHR, csl_pkg::K_NONE, pos, nxt, lcol);
	endtask

	// number cut before a dot that has no digit after it
	task automatic split_dot(logic [15:0] e);
		logic [15:0] d;
		d = (e > tstart) ? e - 16'd1 : e;
		tok(csl_pkg::K_NUMBER, d);
		emit(csl_pkg::ST_TOKEN, csl_pkg::K_DOT, d, e, 16'd0);
	endtask

	task automatic lex_byte(logic [7:0] c, logic [15:0] pos, logic [15:0] nxt);
		bit redo;
		redo = 0;
		case (mode)
			S_OP: begin
				mode = S_IDLE;
				if (c == "=") tok(op_kind(pend) + 6'd1, nxt);
				else begin
					tok(op_kind(pend), pos);
					redo = 1;
				end
			end
			S_SLASH: begin
				if (c == "/") mode = S_LCMT;
				else if (c == "*") mode = S_BLK;
				else begin
					tok(csl_pkg::K_SLASH, pos);
					mode = S_IDLE;
					redo = 1;
				end
			end
			S_LCMT: begin
				if (c == 8'h0A) begin
					mode = S_IDLE;
					redo = 1;
				end
			end
			S_BLK: begin
				if (c == "*") mode = S_BLKSTAR;
				else if (c == 8'h0A) newline(16'd1);
			end
			S_BLKSTAR: begin
				if (c == "/") mode = S_IDLE;
				else if (c != "*") begin
					mode = S_BLK;
					if (c == 8'h0A) newline(16'd1);
				end
			end
			S_STR: begin
				if (c == "\"") begin
					tok(csl_pkg::K_STRING, nxt);
					mode = S_IDLE;
				end else if (c == 8'h0A) newline(16'd1);
			end
			S_INT: begin
				if (c == ".") mode = S_DOT;
				else if (!is_dig(c)) begin
					tok(csl_pkg::K_NUMBER, pos);
					mode = S_IDLE;
					redo = 1;
				end
			end
			S_DOT: begin
				if (is_dig(c)) mode = S_FRAC;
				else begin
					split_dot(pos);
					mode = S_IDLE;
					redo = 1;
				end
			end
			S_FRAC: begin
				if (c == "f") begin
					tok(csl_pkg::K_NUMBER, nxt);
					mode = S_IDLE;
				end else if (!is_dig(c)) begin
					tok(csl_pkg::K_NUMBER, pos);
					mode = S_IDLE;
					redo = 1;
				end
			end
			S_WORD: begin
				if (is_alp(c) || is_dig(c)) begin
					if (pend < WB_LEN) wbuf[pend] = c;
					if (pend != 8'hFF) pend++;
				end else begin
					flush_word(pos);
					mode = S_IDLE;
					redo = 1;
				end
			end
			default: redo = 1;
		endcase
		if (redo) idle_byte(c, pos, nxt);
	endtask

	task automatic clear_scan();
		mode = S_IDLE;
		tstart = '0;
		bpos = '0;
		lcount = 16'd1;
		lcol = '0;
		pend = '0;
	endtask

	task automatic predict_byte(logic [7:0] c, logic last);
		logic [15:0] pos, nxt;
		pos = bpos;
		nxt = (pos == 16'hFFFF) ? pos : pos + 16'd1;
		rn = 0;
		if (lcol != 16'hFFFF) lcol++;
		lex_byte(c, pos, nxt);
		bpos = nxt;
		if (last) begin
			case (mode)
				S_OP: tok(op_kind(pend), nxt);
				S_SLASH: tok(csl_pkg::K_SLASH, nxt);
				S_INT, S_FRAC: tok(csl_pkg::K_NUMBER, nxt);
				S_DOT: split_dot(nxt);
				S_WORD: flush_word(nxt);
				S_STR: emit(csl_pkg::ST_OPENSTR, csl_pkg::K_NONE, tstart, nxt, lcol);
				default: ;
			endcase
			emit(csl_pkg::ST_TOKEN, csl_pkg::K_END, nxt, nxt, 16'd0);
			clear_scan();
		end
		if (rn > 0) rbuf[rn - 1].eor = 1'b1;
		for (int i = 0; i < rn; i++) expected_tokens.push_back(rbuf[i]);
	endtask

	task automatic chk(string name, logic [15:0] e, logic [15:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0d, got %0d", name, e, a);
			fails++;
		end
	endtask

	// sampling side: predict accepted bytes, check delivered tokens
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				predict_byte(char_byte, last_byte);
				char_took = 1;
				accepted++;
			end
			if (token_valid && !token_stall) begin
				if (expected_tokens.size() == 0) begin
					$error("token with nothing expected: kind %0d", token_kind);
					fails++;
				end else begin
					csl_pkg::res_t x;
					x = expected_tokens.pop_front();
					chk("status", 16'(x.status), 16'(status));
					chk("token_kind", 16'(x.kind), 16'(token_kind));
					chk("start_offset", x.start, start_offset);
					chk("lexeme_length", x.len, lexeme_length);
					chk("line_number", x.line, line_number);
					chk("column", x.col, column);
					chk("end_of_run", 16'(x.eor), 16'(end_of_run));
				end
			end
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (arst_n && (!char_valid || char_took)) begin
			if (pending.size() != 0 && pending[0].pause && expected_tokens.size() != 0)
				char_valid <= 1'b0;
			else if (pending.size() != 0 &&
					$urandom_range(0, 99) >= (phase == 0 ? 30 : phase == 1 ? 81 : 0)) begin
				req_t it;
				it = pending.pop_front();
				char_byte <= it.b;
				last_byte <= it.last;
				char_valid <= 1'b1;
				phase = it.ph;
				if (it.hold) hold_req = 1;
			end else
				char_valid <= 1'b0;
		end
		char_took = 0;
	end

	// token receiver, with one long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			token_stall <= 1'b1;
			hold_left--;
		end else
			token_stall <= ($urandom_range(0, 99) < (phase == 0 ? 81 : phase == 1 ? 30 : 0));
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
	endtask

	task automatic end_text(int ph, bit pause, bit hold);
		req_t it;
		for (int i = 0; i < txt.size(); i++) begin
			it.b = txt[i];
			it.last = (i == txt.size() - 1);
			it.pause = pause && i == 0;
			it.hold = hold && i == 0;
			it.ph = ph;
			pending.push_back(it);
			queued++;
		end
		txt.delete();
	endtask

	task automatic random_text(int ph, bit pause, bit hold);
		string frag[] = '{"int", "x1", "3.25f", "42", "\"ab\"", "/*c*\n*/", "//z\n", "#q\n",
			"==", "<=", ">", "!", "(", ")", "\n", " ", "\t", "float3", "7.",
			"/", "*", "struct", "\"o\np\"", "5.5", ";", "\r", "alongname_12x"};
		int n;
		n = $urandom_range(3, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) txt.push_back(byte'($urandom_range(0, 255)));
			else add_str(frag[$urandom_range(0, frag.size() - 1)]);
			if ($urandom_range(0, 2) != 0) add_str(" ");
		end
		end_text(ph, pause, hold);
	endtask

	initial begin
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_byte = '0;
		last_byte = 1'b0;
		token_stall = 1'b0;
		phase = 0;
		accepted = 0;
		queued = 0;
		cycles = 0;
		fails = 0;
		hold_left = 0;
		char_took = 0;
		hold_req = 0;
		clear_scan();

		add_str("(){}[],.-+;*!a!=b=c==>>=<<=/x\n");
		end_text(0, 0, 0);
		// receiver holds off while this text keeps coming
		add_str("struct enum true false static const unsigned short long bool char int ");
		add_str("float NULL float3 ARRAY_");
		add_str("COUNT ARRAY_");
		add_str("COUNTX");
		end_text(0, 0, 1);
		add_str("12 3.5f 4.x 7.\"s\nt\" /*a\n**/ //c\n#d\n&|");
		txt.push_back(8'h00);
		txt.push_back(8'hFF);
		end_text(1, 1, 0);
		add_str("\"open");
		end_text(1, 0, 0);
		add_str("9.");
		end_text(1, 0, 0);
		add_str("a/");
		end_text(2, 0, 0);
		add_str("1.&");
		end_text(2, 0, 0);
		random_text(2, 0, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted < queued || expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0 && expected_tokens.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/csl_pkg.sv
rtl/csl_front.sv
rtl/csl_queue.sv
rtl/c_subset_lexer.sv
test/tb_c_subset_lexer.sv
